// ----- hw/rtl/sha_pkg.sv -----
// Shared types, constants and the rotate helper for the SHA-256 hasher.
`timescale 1ns / 1ps
package sha_pkg;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // source of the byte shifted into the block buffer
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic      shift;     // shift one byte into the buffer
        byte_src_t src;
        logic      count;     // add eight to the bit length
        logic      load;      // working vars <= hash, round counter cleared
        logic      round;     // one compression round
        logic      add;       // hash += working vars
        logic      restart;   // hash, length and word index back to reset
        logic      next_word; // step the digest word index
    } cmd_t;

    typedef struct packed {
        logic fill_63;
        logic fill_56;
        logic round_63;
        logic word_7;
    } sts_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- hw/rtl/sha_ctrl.sv -----
// Sequencing FSM: byte intake, padding, compression rounds and digest output.
`timescale 1ns / 1ps
module sha_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_byte_valid,
    input  logic          in_last,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  sha_pkg::sts_t sts,
    output sha_pkg::cmd_t cmd
);
    import sha_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PAD1  = 8'b0000_0010,
        ST_PADZ  = 8'b0000_0100,
        ST_PADL  = 8'b0000_1000,
        ST_LOAD  = 8'b0001_0000,
        ST_ROUND = 8'b0010_0000,
        ST_ADD   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        cmd.src    = SRC_DATA;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_byte_valid)
                    begin
                        cmd.shift = 1'b1;
                        cmd.count = 1'b1;
                    end
                    if (in_byte_valid && sts.fill_63)
                    begin
                        state_next = ST_LOAD;
                        ret_next   = in_last ? ST_PAD1 : ST_IDLE;
                    end
                    else if (in_last)
                        state_next = ST_PAD1;
                end
            end
            ST_PAD1:
            begin
                cmd.shift = 1'b1;
                cmd.src   = SRC_PAD;
                if (sts.fill_63)
                begin
                    state_next = ST_LOAD;
                    ret_next   = ST_PADZ;
                end
                else
                    state_next = ST_PADZ;
            end
            ST_PADZ:
            begin
                if (sts.fill_56)
                    state_next = ST_PADL;
                else
                begin
                    cmd.shift = 1'b1;
                    cmd.src   = SRC_ZERO;
                    if (sts.fill_63)
                    begin
                        state_next = ST_LOAD;
                        ret_next   = ST_PADZ;
                    end
                end
            end
            ST_PADL:
            begin
                cmd.shift = 1'b1;
                cmd.src   = SRC_LEN;
                if (sts.fill_63)
                begin
                    state_next = ST_LOAD;
                    ret_next   = ST_OUT;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (sts.round_63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ret_reg;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.word_7)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                        cmd.next_word = 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/sha_dp.sv -----
// Datapath: block buffer / schedule window, bit length, working vars, hash.
`timescale 1ns / 1ps
module sha_dp
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    data_byte,
    input  sha_pkg::cmd_t cmd,
    output sha_pkg::sts_t sts,
    output logic [31:0]   digest_word,
    output logic [2:0]    word_index
);
    import sha_pkg::*;

    // first message byte ends up in the top bits; the top word is W[t]
    logic [511:0] buf_reg;
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [5:0]   round_reg;
    logic [2:0]   idx_reg;
    logic [31:0]  hash_reg [8];
    logic [31:0]  v_reg [8];

    logic [7:0]  in_byte;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] s0, s1, big0, big1, ch, maj, t1, t2;

    always_comb
    begin
        case (cmd.src)
            SRC_DATA: in_byte = data_byte;
            SRC_PAD:  in_byte = PAD_BYTE;
            SRC_ZERO: in_byte = 8'h00;
            SRC_LEN:  in_byte = bits_reg[8*(3'd7 - fill_reg[2:0]) +: 8];
            default:  in_byte = 8'h00;
        endcase
    end

    assign w0    = buf_reg[511:480];
    assign w1    = buf_reg[479:448];
    assign w9    = buf_reg[223:192];
    assign w14   = buf_reg[63:32];
    assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign w_new = w0 + s0 + w9 + s1;

    assign big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + ROUND_K[round_reg] + w0;
    assign big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
            buf_reg <= {buf_reg[503:0], in_byte};
        else if (cmd.round)
            buf_reg <= {buf_reg[479:0], w_new};
        if (cmd.load)
            v_reg <= hash_reg;
        else if (cmd.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            hash_reg  <= H_INIT;
        end
        else
        begin
            if (cmd.shift)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.restart)
                bits_reg <= '0;
            else if (cmd.count)
                bits_reg <= bits_reg + 64'd8;
            if (cmd.load)
                round_reg <= '0;
            else if (cmd.round)
                round_reg <= round_reg + 6'd1;
            if (cmd.restart)
                idx_reg <= '0;
            else if (cmd.next_word)
                idx_reg <= idx_reg + 3'd1;
            if (cmd.restart)
                hash_reg <= H_INIT;
            else if (cmd.add)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
        end
    end

    assign sts.fill_63  = (fill_reg == 6'd63);
    assign sts.fill_56  = (fill_reg == LEN_POS);
    assign sts.round_63 = (round_reg == 6'd63);
    assign sts.word_7   = (idx_reg == 3'd7);

    assign digest_word = hash_reg[idx_reg];
    assign word_index  = idx_reg;

endmodule

// ----- hw/rtl/sha256_stream_hasher_core.sv -----
// Top level of the SHA-256 stream hasher.
`timescale 1ns / 1ps
// SHA-256 over a byte stream, one item at a time. An input item with
// tuser set carries one message byte; tlast ends the message and the eight
// digest words follow on the output, most significant first, tlast on the
// eighth. Byte items are taken while the core is idle; the item that fills
// a 64-byte block starts one load, 64 rounds on the single round unit and
// one add. The end mark adds byte-serial padding followed by one or two
// compressions, then eight output items. Input is held off during that work.
module sha256_stream_hasher_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast
);
    import sha_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    sha_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_byte_valid (s_tuser),
        .in_last       (s_tlast),
        .in_ready      (s_tready),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    sha_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .digest_word (digest_word),
        .word_index  (word_index)
    );

    assign m_tdata = {5'd0, word_index, digest_word};
    assign m_tlast = sts.word_7;

endmodule

// ----- verif/tb_sha256_stream_hasher_core.sv -----
// Self-checking testbench for the SHA-256 stream hasher core.
`timescale 1ns / 1ps
module tb_sha256_stream_hasher_core;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    sha256_stream_hasher_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        final_word;
    } digest_item_t;

    byte_item_t   pending_bytes[$];
    digest_item_t digest_queue[$];

    // predictor state
    logic [31:0] hash_st [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] msg_bits;

    int errors;
    int digests_seen;
    int items_sent;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = hash_st[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_st[i] += v[i];
    endtask

    task automatic hasher_restart();
        for (int i = 0; i < 8; i++)
            hash_st[i] = sha_pkg::H_INIT[i];
        fill = 0;
        msg_bits = '0;
    endtask

    task automatic predict_digest(byte_item_t it);
        digest_item_t d;
        if (it.byte_valid)
        begin
            blk[fill] = it.data_byte;
            msg_bits += 64'd8;
            fill++;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        end
        if (!it.last)
            return;
        blk[fill] = sha_pkg::PAD_BYTE;
        fill++;
        if (fill > 56)
        begin
            for (int i = fill; i < 64; i++)
                blk[i] = 8'h00;
            compress();
            fill = 0;
        end
        for (int i = fill; i < 56; i++)
            blk[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            blk[63-i] = msg_bits[8*i +: 8];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            d.word = hash_st[i];
            d.index = 3'(i);
            d.final_word = (i == 7);
            digest_queue = {digest_queue, d};
        end
        hasher_restart();
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    int in_gap;
    bit quiet_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_digest({s_tdata, s_tuser, s_tlast});
                items_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    byte_item_t it;
                    it = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.data_byte;
                    s_tuser  <= it.byte_valid;
                    s_tlast  <= it.last;
                    in_gap   <= quiet_phase ? 0 : gap_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and output stalls
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_gap  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $display("%0t: unexpected digest word %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    digest_item_t e;
                    e = digest_queue.pop_front();
                    digests_seen++;
                    if (m_tdata[31:0] !== e.word)
                    begin
                        $display("%0t: word %0d expected %h actual %h",
                                 $time, e.index, e.word, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[34:32] !== e.index)
                    begin
                        $display("%0t: index expected %0d actual %0d",
                                 $time, e.index, m_tdata[34:32]);
                        errors++;
                    end
                    if (m_tdata[39:35] !== 5'd0)
                    begin
                        $display("%0t: pad bits expected 0 actual %h",
                                 $time, m_tdata[39:35]);
                        errors++;
                    end
                    if (m_tlast !== e.final_word)
                    begin
                        $display("%0t: tlast expected %b actual %b",
                                 $time, e.final_word, m_tlast);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap  <= out_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 3) == 0)
                    out_gap <= gap_len();
            end
        end
    end

    task automatic add_msg(int len, bit with_noise);
        byte_item_t it;
        for (int i = 0; i < len; i++)
        begin
            if (with_noise && $urandom_range(0, 9) == 0)
            begin
                it.data_byte = 8'($urandom);
                it.byte_valid = 1'b0;
                it.last = 1'b0;
                pending_bytes = {pending_bytes, it};
            end
            it.data_byte = 8'($urandom);
            it.byte_valid = 1'b1;
            it.last = 1'b0;
            // sometimes the final byte carries the end mark itself
            if (i == len - 1 && $urandom_range(0, 1))
                it.last = 1'b1;
            pending_bytes = {pending_bytes, it};
            if (it.last)
                return;
        end
        it.data_byte = 8'($urandom);
        it.byte_valid = 1'b0;
        it.last = 1'b1;
        pending_bytes = {pending_bytes, it};
    endtask

    task automatic push_item(logic [7:0] b, logic v, logic l);
        byte_item_t it;
        it.data_byte = b;
        it.byte_valid = v;
        it.last = l;
        pending_bytes = {pending_bytes, it};
    endtask

    int n;
    initial
    begin
        errors = 0;
        digests_seen = 0;
        items_sent = 0;
        quiet_phase = 1'b0;
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        hasher_restart();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, "abc", idle item, extreme bytes
        push_item(8'hff, 1'b0, 1'b1);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hff, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        // lengths around the padding boundary and a full block
        add_msg(55, 1'b0);
        add_msg(56, 1'b0);
        add_msg(63, 1'b0);
        add_msg(64, 1'b0);
        add_msg(65, 1'b0);

        // random messages, mostly short
        n = 0;
        while (n < 140)
        begin
            int len;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 130)
                                              : $urandom_range(0, 20);
            add_msg(len, 1'b1);
            n += len + 1;
            if (n > 60 && n < 90)
                quiet_phase = 1'b1;
            else
                quiet_phase = 1'b0;
        end
        wait (pending_bytes.size() == 0 && !s_tvalid);
        wait (digest_queue.size() == 0);
        repeat (200) @(posedge clk);
        $display("Sent %0d input items, checked %0d digest words (%0d messages).",
                 items_sent, digests_seen, digests_seen / 8);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d digest words outstanding.", digest_queue.size());
        $display("simulation failed");
        $finish;
    end

endmodule
